FILE: hdl/i2cfm_pkg.sv
// Shared types and constants for the I2C memory bus master.
package i2cfm_pkg;

    // Memory size in bytes; the byte address wraps at this size
    localparam int MEM_BYTES = 8192;
    localparam int ADDR_W    = 13;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_HALF_PERIOD    = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd87;
    localparam logic [15:0] HALF_PERIOD_RST    = 16'd100;
    localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd1000;

    // Command codes carried in the action field
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_WRITE_BEGIN = 3'd1;
    localparam logic [2:0] ACT_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] ACT_READ_BEGIN  = 3'd3;
    localparam logic [2:0] ACT_READ_ACK    = 3'd4;
    localparam logic [2:0] ACT_READ_NAK    = 3'd5;
    localparam logic [2:0] ACT_STOP        = 3'd6;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] mem_address;
        logic [7:0]        write_data;
        logic              sda_level;
    } i2cfm_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       no_ack;
        logic       rejected;
    } i2cfm_out_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] half_period_ticks;
        logic [15:0] ack_timeout_ticks;
    } i2cfm_cfg_t;

endpackage

FILE: hdl/i2c_fram_master.sv
// Latency: the result of a tick item appears on m_ the cycle after it is taken on s_.
// Throughput: one tick item per cycle; the bus state machine and output register
//   both advance once per accepted item, so s_ready falls only while m_ stalls.
// Reset: synchronous active-low aresetn; bus idles free (SCL high, SDA released),
//   configuration returns to address 87, 100 ticks per half period, timeout 1000.
module i2c_fram_master (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2cfm_pkg::i2cfm_in_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2cfm_pkg::i2cfm_out_t m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    i2cfm_pkg::i2cfm_cfg_t cfg_reg;
    i2cfm_pkg::i2cfm_out_t res;
    i2cfm_pkg::i2cfm_out_t m_item_reg;
    logic                  m_valid_reg;
    logic                  s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Hold configuration registers; ignore writes past the last index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address    <= i2cfm_pkg::DEVICE_ADDRESS_RST;
            cfg_reg.half_period_ticks <= i2cfm_pkg::HALF_PERIOD_RST;
            cfg_reg.ack_timeout_ticks <= i2cfm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                i2cfm_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address    <= cfg_data[6:0];
                i2cfm_pkg::REG_HALF_PERIOD:    cfg_reg.half_period_ticks <= cfg_data;
                i2cfm_pkg::REG_ACK_TIMEOUT:    cfg_reg.ack_timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cfm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_accept),
        .item    (s_item),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Register the result item; drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_item_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    // Every accepted item yields a result item on the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item produced no result");

    // A waiting result blocks intake only while the sink stalls
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_accept)
        else $error("result overwritten while stalled");

    // With nothing new taken, a delivered result leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !s_accept |=> !m_valid)
        else $error("delivered result repeated");
`endif

endmodule

FILE: hdl/i2cfm_engine.sv
// Bus engine: per-tick state machine that drives SCL/SDA and tracks bytes.
module i2cfm_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  i2cfm_pkg::i2cfm_in_t   item,
    input  i2cfm_pkg::i2cfm_cfg_t  cfg,
    output i2cfm_pkg::i2cfm_out_t  res
);

    typedef enum logic [4:0] {
        PH_IDLE_FREE = 5'd0,
        PH_IDLE_HELD = 5'd1,
        PH_STA_PRE   = 5'd2,
        PH_STA_HIGH  = 5'd3,
        PH_STA_LOW   = 5'd4,
        PH_TX_LOW    = 5'd5,
        PH_TX_HIGH   = 5'd6,
        PH_ACK_LOW   = 5'd7,
        PH_ACK_HIGH  = 5'd8,
        PH_ACK_TAIL  = 5'd9,
        PH_RX_LOW    = 5'd10,
        PH_RX_HIGH   = 5'd11,
        PH_MA_LOW    = 5'd12,
        PH_MA_HIGH   = 5'd13,
        PH_MA_TAIL   = 5'd14,
        PH_SP_LOW    = 5'd15,
        PH_SP_HIGH   = 5'd16,
        PH_SP_REL    = 5'd17
    } phase_t;

    phase_t                       phase_reg,     phase_next;
    logic [2:0]                   byte_step_reg, byte_step_next;
    logic [3:0]                   bit_count_reg, bit_count_next;
    logic [7:0]                   shift_reg,     shift_next;
    logic [15:0]                  tick_reg,      tick_next;
    logic [15:0]                  ack_wait_reg,  ack_wait_next;
    logic [i2cfm_pkg::ADDR_W-1:0] held_addr_reg, held_addr_next;
    logic                         ack_level_reg, ack_level_next;
    logic [2:0]                   cur_op_reg,    cur_op_next;

    // Byte sent at each step of a begin sequence
    function automatic logic [7:0] byte_for_step(
        input logic [2:0]                   step,
        input logic [6:0]                   dev,
        input logic [i2cfm_pkg::ADDR_W-1:0] addr
    );
        logic [15:0] wide;
        begin
            wide = 16'(addr);
            case (step)
                3'd0: byte_for_step = {dev, 1'b0};
                3'd1: byte_for_step = wide[15:8];
                3'd2: byte_for_step = wide[7:0];
                default: byte_for_step = {dev, 1'b1};
            endcase
        end
    endfunction

    // Work out one tick: command intake, line levels, segment advance
    always_comb begin
        logic        idle;
        logic        seg_end;
        logic [15:0] half;
        logic        tx_start;
        logic [7:0]  tx_byte;
        logic [3:0]  bit_inc;

        phase_next     = phase_reg;
        byte_step_next = byte_step_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        ack_wait_next  = ack_wait_reg;
        held_addr_next = held_addr_reg;
        ack_level_next = ack_level_reg;
        cur_op_next    = cur_op_reg;
        tx_start       = 1'b0;
        tx_byte        = 8'd0;
        res            = '0;

        idle = (phase_reg == PH_IDLE_FREE) || (phase_reg == PH_IDLE_HELD);
        half = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;

        // Take a command only while idle; flag it otherwise
        if (item.action >= i2cfm_pkg::ACT_WRITE_BEGIN && item.action <= i2cfm_pkg::ACT_STOP) begin
            if (!idle) begin
                res.rejected = 1'b1;
            end else begin
                cur_op_next = item.action;
                tick_next   = 16'd0;
                if (item.action == i2cfm_pkg::ACT_WRITE_BEGIN ||
                    item.action == i2cfm_pkg::ACT_READ_BEGIN) begin
                    held_addr_next = i2cfm_pkg::ADDR_W'(item.mem_address % i2cfm_pkg::MEM_BYTES);
                    byte_step_next = 3'd0;
                    ack_level_next = 1'b0;
                    phase_next = (phase_reg == PH_IDLE_HELD) ? PH_STA_PRE : PH_STA_HIGH;
                end else if (item.action == i2cfm_pkg::ACT_WRITE_BYTE) begin
                    ack_level_next = 1'b0;
                    byte_step_next = 3'd0;
                    shift_next     = item.write_data;
                    bit_count_next = 4'd0;
                    phase_next     = PH_TX_LOW;
                end else if (item.action == i2cfm_pkg::ACT_READ_ACK ||
                             item.action == i2cfm_pkg::ACT_READ_NAK) begin
                    shift_next     = 8'd0;
                    bit_count_next = 4'd0;
                    phase_next     = PH_RX_LOW;
                end else begin
                    phase_next = PH_SP_LOW;
                end
            end
        end

        // Drive the lines from the phase in effect this tick
        res.busy_res = !((phase_next == PH_IDLE_FREE) || (phase_next == PH_IDLE_HELD));
        case (phase_next)
            PH_IDLE_FREE, PH_STA_HIGH, PH_ACK_HIGH, PH_RX_HIGH, PH_SP_REL: begin
                res.scl_level = 1'b1;  res.sda_pull_low = 1'b0;
            end
            PH_STA_LOW: begin
                res.scl_level = 1'b1;  res.sda_pull_low = 1'b1;
            end
            PH_TX_LOW: begin
                res.scl_level = 1'b0;  res.sda_pull_low = !shift_next[7];
            end
            PH_TX_HIGH: begin
                res.scl_level = 1'b1;  res.sda_pull_low = !shift_next[7];
            end
            PH_MA_LOW, PH_MA_TAIL: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = (cur_op_next == i2cfm_pkg::ACT_READ_ACK);
            end
            PH_MA_HIGH: begin
                res.scl_level    = 1'b1;
                res.sda_pull_low = (cur_op_next == i2cfm_pkg::ACT_READ_ACK);
            end
            PH_SP_LOW: begin
                res.scl_level = 1'b0;  res.sda_pull_low = 1'b1;
            end
            PH_SP_HIGH: begin
                res.scl_level = 1'b1;  res.sda_pull_low = 1'b1;
            end
            default: begin
                res.scl_level = 1'b0;  res.sda_pull_low = 1'b0;
            end
        endcase

        // Advance the half-period segment
        seg_end = ({1'b0, tick_next} + 17'd1) >= {1'b0, half};
        bit_inc = bit_count_next + 4'd1;
        if (res.busy_res) begin
            if (phase_next == PH_ACK_HIGH) begin
                if (!seg_end) begin
                    tick_next = tick_next + 16'd1;
                end else if (!item.sda_level) begin
                    tick_next  = 16'd0;
                    phase_next = PH_ACK_TAIL;
                end else if (ack_wait_next >= cfg.ack_timeout_ticks) begin
                    ack_level_next = 1'b1;
                    tick_next      = 16'd0;
                    phase_next     = PH_ACK_TAIL;
                end else begin
                    ack_wait_next = ack_wait_next + 16'd1;
                end
            end else if (!seg_end) begin
                tick_next = tick_next + 16'd1;
            end else begin
                tick_next = 16'd0;
                case (phase_next)
                    PH_STA_PRE:  phase_next = PH_STA_HIGH;
                    PH_STA_HIGH: phase_next = PH_STA_LOW;
                    PH_STA_LOW: begin
                        tx_start = 1'b1;
                        tx_byte  = byte_for_step(byte_step_next, cfg.device_address,
                                                 held_addr_next);
                    end
                    PH_TX_LOW: phase_next = PH_TX_HIGH;
                    PH_TX_HIGH: begin
                        bit_count_next = bit_inc;
                        shift_next     = {shift_next[6:0], 1'b0};
                        if (bit_inc >= 4'd8) begin
                            ack_wait_next = 16'd0;
                            phase_next    = PH_ACK_LOW;
                        end else begin
                            phase_next = PH_TX_LOW;
                        end
                    end
                    PH_ACK_LOW: begin
                        ack_wait_next = 16'd0;
                        phase_next    = PH_ACK_HIGH;
                    end
                    PH_ACK_TAIL: begin
                        byte_step_next = byte_step_next + 3'd1;
                        if (cur_op_next == i2cfm_pkg::ACT_WRITE_BEGIN) begin
                            if (byte_step_next >= 3'd3) begin
                                phase_next = PH_IDLE_HELD;
                            end else begin
                                tx_start = 1'b1;
                                tx_byte  = byte_for_step(byte_step_next, cfg.device_address,
                                                         held_addr_next);
                            end
                        end else if (cur_op_next == i2cfm_pkg::ACT_READ_BEGIN) begin
                            if (byte_step_next < 3'd3) begin
                                tx_start = 1'b1;
                                tx_byte  = byte_for_step(byte_step_next, cfg.device_address,
                                                         held_addr_next);
                            end else if (byte_step_next == 3'd3) begin
                                phase_next = PH_STA_PRE;
                            end else begin
                                phase_next = PH_IDLE_HELD;
                            end
                        end else begin
                            phase_next = PH_IDLE_HELD;
                        end
                    end
                    PH_RX_LOW: phase_next = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        shift_next     = {shift_next[6:0], item.sda_level};
                        bit_count_next = bit_inc;
                        phase_next     = (bit_inc >= 4'd8) ? PH_MA_LOW : PH_RX_LOW;
                    end
                    PH_MA_LOW:  phase_next = PH_MA_HIGH;
                    PH_MA_HIGH: phase_next = PH_MA_TAIL;
                    PH_MA_TAIL: begin
                        res.read_valid = 1'b1;
                        res.read_data  = shift_next;
                        phase_next     = PH_IDLE_HELD;
                    end
                    PH_SP_LOW:  phase_next = PH_SP_HIGH;
                    PH_SP_HIGH: phase_next = PH_SP_REL;
                    default:    phase_next = PH_IDLE_FREE;
                endcase
            end
        end

        // Load the next byte to send
        if (tx_start) begin
            shift_next     = tx_byte;
            bit_count_next = 4'd0;
            phase_next     = PH_TX_LOW;
        end

        res.no_ack = ack_level_next;
    end

    // Hold bus state; advance once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE_FREE;
            byte_step_reg <= 3'd0;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= 16'd0;
            ack_wait_reg  <= 16'd0;
            held_addr_reg <= '0;
            ack_level_reg <= 1'b0;
            cur_op_reg    <= i2cfm_pkg::ACT_NONE;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            byte_step_reg <= byte_step_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            ack_wait_reg  <= ack_wait_next;
            held_addr_reg <= held_addr_next;
            ack_level_reg <= ack_level_next;
            cur_op_reg    <= cur_op_next;
        end
    end

`ifndef ASSERT_OFF
    // A rejected command leaves the engine busy
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.rejected |-> res.busy_res)
        else $error("rejected command on an idle engine");

    // Read data appears only at the end of the master ack slot
    a_rd_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.read_valid |-> phase_reg == PH_MA_TAIL)
        else $error("read data outside the master ack tail");

    // Bit counter never passes one byte
    a_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= 4'd8)
        else $error("bit counter overran a byte");

    // A finished read leaves the engine idle with SCL held low
    a_rd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.read_valid |=> phase_reg == PH_IDLE_HELD)
        else $error("engine not held idle after read");
`endif

endmodule
